// ===== sv/sprite_sheet_frame_animator_macros.svh =====
// Assertion macros for the sprite sheet frame animator.
// Included by the RTL files that assert; define SYNTH to compile them out.
`ifndef SPRITE_SHEET_FRAME_ANIMATOR_MACROS_SVH
`define SPRITE_SHEET_FRAME_ANIMATOR_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define SSFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define SSFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define SSFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SSFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/ssfa_pkg.sv =====
// Shared types, constants and the control store of the frame animator.
// No dependencies; used by the interfaces, the divider and the top level.
`timescale 1ns / 1ps
package ssfa_pkg;

  localparam int MAX_COLUMNS = 16;
  localparam int MAX_ROWS    = 16;

  localparam int OP_W      = 2;
  localparam int MS_W      = 16;
  localparam int COUNT_W   = 25;
  localparam int CNT_W     = 5;
  localparam int N_W       = 10;
  localparam int DIM_W     = 10;
  localparam int ORG_W     = 12;
  localparam int COORD_W   = 15;
  localparam int FRAME_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int DIV_CNT_W = $clog2(COUNT_W + 1);
  localparam int STEP_W    = 4;

  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_X  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP   = 3'd7;

  localparam logic [COORD_W-1:0] COORD_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Program steps
  localparam logic [STEP_W-1:0] S_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] S_DISP    = 4'd1;
  localparam logic [STEP_W-1:0] S_LOADD   = 4'd2;
  localparam logic [STEP_W-1:0] S_WAITD   = 4'd3;
  localparam logic [STEP_W-1:0] S_CHK     = 4'd4;
  localparam logic [STEP_W-1:0] S_LOOPCHK = 4'd5;
  localparam logic [STEP_W-1:0] S_LOADN   = 4'd6;
  localparam logic [STEP_W-1:0] S_WAITN   = 4'd7;
  localparam logic [STEP_W-1:0] S_WRAP    = 4'd8;
  localparam logic [STEP_W-1:0] S_NOWRAP  = 4'd9;
  localparam logic [STEP_W-1:0] S_FINEND  = 4'd10;
  localparam logic [STEP_W-1:0] S_OPS     = 4'd11;
  localparam logic [STEP_W-1:0] S_COLROW  = 4'd12;
  localparam logic [STEP_W-1:0] S_WAITC   = 4'd13;
  localparam logic [STEP_W-1:0] S_CORNER  = 4'd14;
  localparam logic [STEP_W-1:0] S_HOLD    = 4'd15;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_IDLE,
    ACT_SUM,
    ACT_DIV_SUM,
    ACT_SAVE_REM,
    ACT_DIV_Q,
    ACT_WRAP,
    ACT_NOWRAP,
    ACT_FIN_END,
    ACT_OP,
    ACT_DIV_FRAME,
    ACT_EMIT
  } act_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_SKIP_TICK,
    COND_DIV_BUSY,
    COND_NO_WRAP,
    COND_NO_LOOP,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    act_e              act;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic                 start;
    logic [COUNT_W-1:0]   dividend;
    logic [MS_W-1:0]      divisor;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic [COUNT_W-1:0] quo;
    logic [MS_W-1:0]    rem;
  } div_rsp_t;

  // Control store: a taken condition jumps to target, otherwise advance.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      S_IDLE:    w = '{ACT_IDLE,      COND_NO_INPUT,  S_IDLE};
      S_DISP:    w = '{ACT_SUM,       COND_SKIP_TICK, S_OPS};
      S_LOADD:   w = '{ACT_DIV_SUM,   COND_NEXT,      S_IDLE};
      S_WAITD:   w = '{ACT_NONE,      COND_DIV_BUSY,  S_WAITD};
      S_CHK:     w = '{ACT_SAVE_REM,  COND_NO_WRAP,   S_NOWRAP};
      S_LOOPCHK: w = '{ACT_NONE,      COND_NO_LOOP,   S_FINEND};
      S_LOADN:   w = '{ACT_DIV_Q,     COND_NEXT,      S_IDLE};
      S_WAITN:   w = '{ACT_NONE,      COND_DIV_BUSY,  S_WAITN};
      S_WRAP:    w = '{ACT_WRAP,      COND_ALWAYS,    S_COLROW};
      S_NOWRAP:  w = '{ACT_NOWRAP,    COND_ALWAYS,    S_COLROW};
      S_FINEND:  w = '{ACT_FIN_END,   COND_ALWAYS,    S_COLROW};
      S_OPS:     w = '{ACT_OP,        COND_NEXT,      S_IDLE};
      S_COLROW:  w = '{ACT_DIV_FRAME, COND_NEXT,      S_IDLE};
      S_WAITC:   w = '{ACT_NONE,      COND_DIV_BUSY,  S_WAITC};
      S_CORNER:  w = '{ACT_EMIT,      COND_OUT_FREE,  S_IDLE};
      default:   w = '{ACT_NONE,      COND_ALWAYS,    S_CORNER};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/ssfa_in_if.sv =====
// Input channel of the frame animator: valid/ready plus one input item.
// Depends on ssfa_pkg for field widths.
`timescale 1ns / 1ps
interface ssfa_in_if;
  import ssfa_pkg::*;

  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [MS_W-1:0] elapsed_ms;

  modport source (output valid, operation, elapsed_ms, input ready);
  modport sink   (input valid, operation, elapsed_ms, output ready);
endinterface

// ===== sv/ssfa_out_if.sv =====
// Result channel of the frame animator: valid/ready plus one result item.
// Depends on ssfa_pkg for field widths.
`timescale 1ns / 1ps
interface ssfa_out_if;
  import ssfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_index;
  logic [COORD_W-1:0] source_x;
  logic [COORD_W-1:0] source_y;
  logic               is_finished;
  logic               wrapped_now;

  modport source (output valid, frame_index, source_x, source_y, is_finished,
                  wrapped_now, input ready);
  modport sink   (input valid, frame_index, source_x, source_y, is_finished,
                  wrapped_now, output ready);
endinterface

// ===== sv/ssfa_divider.sv =====
// Restoring serial divider, one quotient bit per cycle, shared by every divide step.
// Depends on ssfa_pkg for request/response types and widths.
`timescale 1ns / 1ps
module ssfa_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssfa_pkg::div_req_t req_i,
  output ssfa_pkg::div_rsp_t rsp_o
);
  import ssfa_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [COUNT_W-1:0]   quo_q;
  logic [MS_W-1:0]      rem_q;
  logic [MS_W-1:0]      dvs_q;
  logic [MS_W:0]        trial;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_q, quo_q[COUNT_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[COUNT_W-2:0], fits};
      rem_q <= fits ? MS_W'(trial - {1'b0, dvs_q}) : trial[MS_W-1:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== sv/sprite_sheet_frame_animator.sv =====
// Sprite sheet frame animator: a control-store sequencer over one serial divider.
// Each item ends with a frame-by-columns divide for the corner; a plain tick first
// divides its sum by the delay, and one that wraps divides that quotient by cols*rows.
// One item in flight; the next is taken in the cycle after its result is registered.
// Each divide runs on the 25-bit serial divider, one bit per cycle.
// Reset (async, low) clears the time counter, frame, flags and loads register defaults.
`timescale 1ns / 1ps
`include "sprite_sheet_frame_animator_macros.svh"
module sprite_sheet_frame_animator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssfa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ssfa_pkg::CFG_W-1:0]     cfg_data_i,
  ssfa_in_if.sink                        in_i,
  ssfa_out_if.source                     out_o
);
  import ssfa_pkg::*;

  // Configuration registers
  logic [MS_W-1:0]  delay_q;
  logic [CNT_W-1:0] cols_q;
  logic [CNT_W-1:0] rows_q;
  logic [DIM_W-1:0] fw_q;
  logic [DIM_W-1:0] fh_q;
  logic [ORG_W-1:0] ox_q;
  logic [ORG_W-1:0] oy_q;
  logic             loop_q;

  // Animation state
  logic [COUNT_W-1:0] elapsed_q;
  logic [FRAME_W-1:0] frame_q;
  logic               finished_q;
  logic               wrapped_q;

  // Sequencer and working registers
  logic [STEP_W-1:0]  pc_q;
  logic [STEP_W-1:0]  pc_d;
  logic [OP_W-1:0]    op_q;
  logic [MS_W-1:0]    ms_q;
  logic [COUNT_W-1:0] sum_q;
  logic [MS_W-1:0]    remd_q;
  logic               out_valid_q;

  uword_t   uw;
  logic     take;
  logic     out_free;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [CNT_W-1:0]   cols_c;
  logic [CNT_W-1:0]   rows_c;
  logic [N_W-1:0]     n_c;
  logic [COUNT_W:0]   sum_full;
  logic [COUNT_W-1:0] sum_c;
  logic [COUNT_W:0]   wrap_prod;
  logic [CNT_W-1:0]   col_c;
  logic [FRAME_W-1:0] row_c;
  logic [COORD_W-1:0] sx_prod;
  logic [COORD_W:0]   sx_sum;
  logic [17:0]        sy_prod;
  logic [18:0]        sy_sum;

  ssfa_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Column and row counts: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (cols_q == '0) begin
      cols_c = CNT_W'(1);
    end else if (int'(cols_q) > MAX_COLUMNS) begin
      cols_c = CNT_W'(MAX_COLUMNS);
    end else begin
      cols_c = cols_q;
    end
    if (rows_q == '0) begin
      rows_c = CNT_W'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      rows_c = CNT_W'(MAX_ROWS);
    end else begin
      rows_c = rows_q;
    end
  end

  assign n_c      = N_W'(cols_c) * N_W'(rows_c);
  assign sum_full = {1'b0, elapsed_q} + (COUNT_W + 1)'(ms_q);
  assign sum_c    = sum_full[COUNT_W] ? COUNT_MAX : sum_full[COUNT_W-1:0];

  // Wrapped time: (q mod N) * delay + (sum mod delay)
  assign wrap_prod = (COUNT_W + 1)'(div_rsp.rem[N_W-1:0]) * (COUNT_W + 1)'(delay_q);

  assign col_c   = div_rsp.rem[CNT_W-1:0];
  assign row_c   = div_rsp.quo[FRAME_W-1:0];
  assign sx_prod = COORD_W'(fw_q) * COORD_W'(col_c);
  assign sx_sum  = (COORD_W + 1)'(ox_q) + {1'b0, sx_prod};
  assign sy_prod = 18'(fh_q) * 18'(row_c);
  assign sy_sum  = 19'(oy_q) + {1'b0, sy_prod};

  assign out_free = !out_valid_q || out_o.ready;

  // Sequencer
  assign uw = ucode(pc_q);

  always_comb begin
    case (uw.cond)
      COND_NEXT:      take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_INPUT:  take = !in_i.valid;
      COND_SKIP_TICK: take = (op_q != OP_TICK) || finished_q || (delay_q == '0);
      COND_DIV_BUSY:  take = div_rsp.busy;
      COND_NO_WRAP:   take = div_rsp.quo < COUNT_W'(n_c);
      COND_NO_LOOP:   take = !loop_q;
      COND_OUT_FREE:  take = out_free;
      default:        take = 1'b0;
    endcase
    pc_d = take ? uw.target : STEP_W'(pc_q + 1'b1);
  end

  assign in_i.ready = (uw.act == ACT_IDLE);

  // Divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = sum_q;
    div_req.divisor  = delay_q;
    div_req.steps    = DIV_CNT_W'(COUNT_W);
    case (uw.act)
      ACT_DIV_SUM: begin
        div_req.start = 1'b1;
      end
      ACT_DIV_Q: begin
        div_req.start    = 1'b1;
        div_req.dividend = div_rsp.quo;
        div_req.divisor  = MS_W'(n_c);
      end
      ACT_DIV_FRAME: begin
        // Left-align the frame so only its bits are walked.
        div_req.start    = 1'b1;
        div_req.dividend = {frame_q, {(COUNT_W - FRAME_W){1'b0}}};
        div_req.divisor  = MS_W'(cols_c);
        div_req.steps    = DIV_CNT_W'(FRAME_W);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
      cols_q  <= CNT_W'(1);
      rows_q  <= CNT_W'(1);
      fw_q    <= '0;
      fh_q    <= '0;
      ox_q    <= '0;
      oy_q    <= '0;
      loop_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DELAY: delay_q <= cfg_data_i;
        CFG_COLS:  cols_q  <= cfg_data_i[CNT_W-1:0];
        CFG_ROWS:  rows_q  <= cfg_data_i[CNT_W-1:0];
        CFG_FW:    fw_q    <= cfg_data_i[DIM_W-1:0];
        CFG_FH:    fh_q    <= cfg_data_i[DIM_W-1:0];
        CFG_ORG_X: ox_q    <= cfg_data_i[ORG_W-1:0];
        CFG_ORG_Y: oy_q    <= cfg_data_i[ORG_W-1:0];
        CFG_LOOP:  loop_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Animation state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q  <= '0;
      frame_q    <= '0;
      finished_q <= 1'b0;
      wrapped_q  <= 1'b0;
    end else begin
      case (uw.act)
        ACT_WRAP: begin
          elapsed_q <= wrap_prod[COUNT_W-1:0] + COUNT_W'(remd_q);
          frame_q   <= div_rsp.rem[FRAME_W-1:0];
          wrapped_q <= 1'b1;
        end
        ACT_NOWRAP: begin
          elapsed_q <= sum_q;
          frame_q   <= div_rsp.quo[FRAME_W-1:0];
          wrapped_q <= 1'b0;
        end
        ACT_FIN_END: begin
          // Keep the added time, freeze the frame.
          elapsed_q  <= sum_q;
          finished_q <= 1'b1;
        end
        ACT_OP: begin
          if (op_q == OP_RESTART) begin
            elapsed_q  <= '0;
            frame_q    <= '0;
            finished_q <= 1'b0;
            wrapped_q  <= 1'b0;
          end else if (op_q == OP_FINISH) begin
            finished_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q <= in_i.operation;
      ms_q <= in_i.elapsed_ms;
    end
    if (uw.act == ACT_SUM) begin
      sum_q <= sum_c;
    end
    if (uw.act == ACT_SAVE_REM) begin
      remd_q <= div_rsp.rem;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uw.act == ACT_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.act == ACT_EMIT && out_free) begin
      out_o.frame_index <= frame_q;
      out_o.source_x    <= sx_sum[COORD_W] ? COORD_MAX : sx_sum[COORD_W-1:0];
      out_o.source_y    <= (sy_sum > 19'(COORD_MAX)) ? COORD_MAX : sy_sum[COORD_W-1:0];
      out_o.is_finished <= finished_q;
      out_o.wrapped_now <= wrapped_q;
    end
  end

  assign out_o.valid = out_valid_q;

  `SSFA_ASSERT_IMP(a_idle_div_quiet, clk_i, rst_ni, pc_q == S_IDLE, !div_rsp.busy)
  `SSFA_ASSERT_NXT(a_accept_dispatch, clk_i, rst_ni, in_i.valid && in_i.ready, pc_q == S_DISP)
  `SSFA_ASSERT_IMP(a_finish_source, clk_i, rst_ni, $rose(finished_q), ($past(pc_q) == S_FINEND) || ($past(pc_q) == S_OPS))
  `SSFA_ASSERT_NXT(a_emit_valid, clk_i, rst_ni, (pc_q == S_CORNER) && out_free, out_o.valid)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the sprite sheet frame animator: walks a directed table, then
// random register settings and tick/restart/finish traffic, checked by an in-bench predictor.
// Depends on ssfa_pkg, ssfa_in_if, ssfa_out_if and the sprite_sheet_frame_animator RTL.
`timescale 1ns / 1ps
module tb_top;
  import ssfa_pkg::*;

  localparam logic [OP_W-1:0] OP_PEEK = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic               done;
    logic               wrapped;
  } frame_pos_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [OP_W-1:0]      op;
    logic [CFG_W-1:0]     value;
    logic                 typed;
    frame_pos_t           want;
  } script_row_t;

  localparam logic [CFG_IDX_W-1:0] ALL_REGS [8] = '{CFG_DELAY, CFG_COLS, CFG_ROWS, CFG_FW,
                                                  CFG_FH, CFG_ORG_X, CFG_ORG_Y, CFG_LOOP};

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  ssfa_in_if  in_if ();
  ssfa_out_if out_if ();

  sprite_sheet_frame_animator DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Register shadow, reset values.
  logic [15:0] reg_delay = '0;
  logic [4:0]  reg_cols  = 5'd1;
  logic [4:0]  reg_rows  = 5'd1;
  logic [9:0]  reg_fw    = '0;
  logic [9:0]  reg_fh    = '0;
  logic [11:0] reg_org_x = '0;
  logic [11:0] reg_org_y = '0;
  logic        reg_loop  = 1'b1;

  // Animation state.
  logic [COUNT_W-1:0] anim_ms     = '0;
  logic [FRAME_W-1:0] anim_frame  = '0;
  logic               anim_done   = 1'b0;
  logic               anim_wrap   = 1'b0;

  frame_pos_t  pending_frames [$];
  script_row_t script [32];
  int          mismatch_count = 0;
  bit          quiet = 1'b0;
  bit          hold_out = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned clamp_dim(input logic [4:0] v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Apply one transaction to the animation state and return the reported position.
  function automatic frame_pos_t advance_animation(input logic [OP_W-1:0] op,
                                                   input logic [MS_W-1:0] ms);
    frame_pos_t      res;
    int unsigned     ncols;
    int unsigned     nrows;
    longint unsigned span;
    longint unsigned sum;
    longint unsigned pos;
    ncols = clamp_dim(reg_cols, MAX_COLUMNS);
    nrows = clamp_dim(reg_rows, MAX_ROWS);
    case (op)
      OP_TICK: begin
        if (!anim_done && reg_delay != 0) begin
          span = longint'(reg_delay) * ncols * nrows;
          sum = longint'(anim_ms) + ms;
          if (sum > COUNT_MAX) sum = COUNT_MAX;
          if (sum >= span) begin
            if (reg_loop) begin
              anim_wrap = 1'b1;
              sum = sum % span;
              anim_frame = FRAME_W'(sum / reg_delay);
            end else begin
              anim_done = 1'b1;
            end
          end else begin
            anim_wrap = 1'b0;
            anim_frame = FRAME_W'(sum / reg_delay);
          end
          anim_ms = COUNT_W'(sum);
        end
      end
      OP_RESTART: begin
        anim_done = 1'b0;
        anim_wrap = 1'b0;
        anim_frame = '0;
        anim_ms = '0;
      end
      OP_FINISH: anim_done = 1'b1;
      default: ;
    endcase
    res.frame = anim_frame;
    pos = longint'(reg_org_x) + longint'(reg_fw) * (anim_frame % ncols);
    res.src_x = (pos > COORD_MAX) ? COORD_MAX : COORD_W'(pos);
    pos = longint'(reg_org_y) + longint'(reg_fh) * (anim_frame / ncols);
    res.src_y = (pos > COORD_MAX) ? COORD_MAX : COORD_W'(pos);
    res.done = anim_done;
    res.wrapped = anim_wrap;
    return res;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [MS_W-1:0] ms,
                           input logic typed, input frame_pos_t want);
    frame_pos_t model;
    while (!quiet && $urandom_range(99) < 23) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.elapsed_ms <= ms;
    do @(negedge clk); while (!in_if.ready);
    @(posedge clk);
    model = advance_animation(op, ms);
    pending_frames.push_back(typed ? want : model);
  endtask

  // Drop valid and hold until every outstanding result has been taken.
  task automatic settle_pipeline();
    in_if.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    settle_pipeline();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DELAY: reg_delay = data;
      CFG_COLS:  reg_cols  = data[4:0];
      CFG_ROWS:  reg_rows  = data[4:0];
      CFG_FW:    reg_fw    = data[9:0];
      CFG_FH:    reg_fh    = data[9:0];
      CFG_ORG_X: reg_org_x = data[11:0];
      CFG_ORG_Y: reg_org_y = data[11:0];
      CFG_LOOP:  reg_loop  = data[0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_W-1:0] pick_reg_value(input logic [CFG_IDX_W-1:0] idx);
    int unsigned      r;
    logic [CFG_W-1:0] v;
    r = $urandom_range(99);
    v = CFG_W'($urandom);
    case (idx)
      CFG_DELAY: begin
        if (r < 6) v = '0;
        else if (r < 12) v = '1;
        else if (r < 60) v = CFG_W'($urandom_range(1, 12));
        else v = CFG_W'($urandom_range(13, 3000));
      end
      CFG_COLS, CFG_ROWS: begin
        if (r < 10) v[4:0] = 5'd0;
        else if (r < 20) v[4:0] = 5'($urandom_range(17, 31));
        else if (r < 30) v[4:0] = 5'd16;
        else if (r < 40) v[4:0] = 5'd1;
        else v[4:0] = 5'($urandom_range(2, 8));
      end
      CFG_FW, CFG_FH: begin
        if (r < 15) v[9:0] = '1;
        else if (r < 25) v[9:0] = '0;
      end
      CFG_ORG_X, CFG_ORG_Y: begin
        if (r < 15) v[11:0] = '1;
        else if (r < 25) v[11:0] = '0;
      end
      CFG_LOOP: v[0] = (r < 70);
      default: ;
    endcase
    return v;
  endfunction

  // Mostly steps on the scale of the frame delay, with extremes mixed in.
  function automatic logic [MS_W-1:0] pick_ms();
    int unsigned r;
    int unsigned span;
    r = $urandom_range(99);
    span = int'(reg_delay) * 3;
    if (span > 65535) span = 65535;
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 75) return MS_W'($urandom_range(span, 0));
    return MS_W'($urandom);
  endfunction

  // Result receiver: random back-pressure, plus one long hold on request.
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end
      out_if.ready <= quiet || ($urandom_range(99) >= 23);
    end
  end

  // Result checker; handshake signals are stable at the falling edge.
  always @(negedge clk) begin
    frame_pos_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected result frame %0d", out_if.frame_index));
      end else begin
        want = pending_frames.pop_front();
        if (out_if.frame_index !== want.frame)
          report_mismatch($sformatf("frame_index got %0d want %0d",
                                    out_if.frame_index, want.frame));
        if (out_if.source_x !== want.src_x)
          report_mismatch($sformatf("source_x got %0d want %0d", out_if.source_x, want.src_x));
        if (out_if.source_y !== want.src_y)
          report_mismatch($sformatf("source_y got %0d want %0d", out_if.source_y, want.src_y));
        if (out_if.is_finished !== want.done)
          report_mismatch($sformatf("is_finished got %0b want %0b",
                                    out_if.is_finished, want.done));
        if (out_if.wrapped_now !== want.wrapped)
          report_mismatch($sformatf("wrapped_now got %0b want %0b",
                                    out_if.wrapped_now, want.wrapped));
      end
    end
  end

  initial begin
    int unsigned      sent;
    int unsigned      phase;
    int unsigned      burst;
    int unsigned      r;
    logic [OP_W-1:0]  op;
    in_if.valid <= 1'b0;
    in_if.operation <= OP_TICK;
    in_if.elapsed_ms <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_DELAY;
    cfg_data <= '0;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    script = '{
      // frozen animation and flag ops under reset settings
      '{ROW_ITEM, CFG_DELAY, OP_TICK,    16'hFFFF, 1'b1, '{8'd0, 15'd0, 15'd0, 1'b0, 1'b0}},
      '{ROW_ITEM, CFG_DELAY, OP_PEEK,    16'd0,    1'b1, '{8'd0, 15'd0, 15'd0, 1'b0, 1'b0}},
      '{ROW_ITEM, CFG_DELAY, OP_FINISH,  16'd0,    1'b1, '{8'd0, 15'd0, 15'd0, 1'b1, 1'b0}},
      '{ROW_ITEM, CFG_DELAY, OP_TICK,    16'd5,    1'b1, '{8'd0, 15'd0, 15'd0, 1'b1, 1'b0}},
      '{ROW_ITEM, CFG_DELAY, OP_RESTART, 16'd0,    1'b1, '{8'd0, 15'd0, 15'd0, 1'b0, 1'b0}},
      '{ROW_REG,  CFG_DELAY, OP_TICK,    16'd10,   1'b0, '0},
      '{ROW_REG,  CFG_COLS,  OP_TICK,    16'd4,    1'b0, '0},
      '{ROW_REG,  CFG_ROWS,  OP_TICK,    16'd4,    1'b0, '0},
      '{ROW_REG,  CFG_FW,    OP_TICK,    16'd1023, 1'b0, '0},
      '{ROW_REG,  CFG_FH,    OP_TICK,    16'd1023, 1'b0, '0},
      '{ROW_REG,  CFG_ORG_X, OP_TICK,    16'd4095, 1'b0, '0},
      '{ROW_REG,  CFG_ORG_Y, OP_TICK,    16'd4095, 1'b0, '0},
      '{ROW_REG,  CFG_LOOP,  OP_TICK,    16'd1,    1'b0, '0},
      // 4x4 sheet, 10 ms per frame: last frame, then wrap
      '{ROW_ITEM, CFG_DELAY, OP_TICK,    16'd0,    1'b1,
        '{8'd0, 15'd4095, 15'd4095, 1'b0, 1'b0}},
      '{ROW_ITEM, CFG_DELAY, OP_TICK,    16'd25,   1'b0, '0},
      '{ROW_ITEM, CFG_DELAY, OP_TICK,    16'd134,  1'b1,
        '{8'd15, 15'd7164, 15'd7164, 1'b0, 1'b0}},
      '{ROW_ITEM, CFG_DELAY, OP_TICK,    16'd1,    1'b1,
        '{8'd0, 15'd4095, 15'd4095, 1'b0, 1'b1}},
      '{ROW_ITEM, CFG_DELAY, OP_TICK,    16'hFFFF, 1'b0, '0},
      '{ROW_ITEM, CFG_DELAY, OP_TICK,    16'd10,   1'b0, '0},
      // zero and oversized column counts, frame beyond the sheet
      '{ROW_REG,  CFG_COLS,  OP_TICK,    16'd0,    1'b0, '0},
      '{ROW_ITEM, CFG_DELAY, OP_PEEK,    16'd0,    1'b0, '0},
      '{ROW_REG,  CFG_COLS,  OP_TICK,    16'd31,   1'b0, '0},
      '{ROW_REG,  CFG_ROWS,  OP_TICK,    16'd31,   1'b0, '0},
      '{ROW_REG,  CFG_DELAY, OP_TICK,    16'd1,    1'b0, '0},
      '{ROW_ITEM, CFG_DELAY, OP_TICK,    16'd200,  1'b0, '0},
      '{ROW_REG,  CFG_COLS,  OP_TICK,    16'd0,    1'b0, '0},
      // row 49 on a one-column sheet saturates the y corner
      '{ROW_ITEM, CFG_DELAY, OP_PEEK,    16'd0,    1'b1,
        '{8'd49, 15'd4095, 15'd32767, 1'b0, 1'b1}},
      '{ROW_REG,  CFG_ROWS,  OP_TICK,    16'd0,    1'b0, '0},
      '{ROW_REG,  CFG_LOOP,  OP_TICK,    16'd0,    1'b0, '0},
      // end without looping keeps frame and wrap flag
      '{ROW_ITEM, CFG_DELAY, OP_TICK,    16'd1,    1'b1,
        '{8'd49, 15'd4095, 15'd32767, 1'b1, 1'b1}},
      '{ROW_ITEM, CFG_DELAY, OP_RESTART, 16'd0,    1'b1,
        '{8'd0, 15'd4095, 15'd4095, 1'b0, 1'b0}},
      '{ROW_ITEM, CFG_DELAY, OP_TICK,    16'd3,    1'b0, '0}
    };

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG)
        write_reg(script[i].reg_idx, script[i].value);
      else
        send_item(script[i].op, script[i].value, script[i].typed, script[i].want);
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      phase++;
      quiet = (phase == 6 || phase == 7);
      foreach (ALL_REGS[k])
        write_reg(ALL_REGS[k], pick_reg_value(ALL_REGS[k]));
      // back up the result side while items keep coming
      if (phase == 3) hold_out = 1'b1;
      burst = $urandom_range(20, 60);
      repeat (burst) begin
        r = $urandom_range(99);
        if (anim_done && r < 40) op = OP_RESTART;
        else if (r < 78) op = OP_TICK;
        else if (r < 86) op = OP_RESTART;
        else if (r < 92) op = OP_FINISH;
        else op = OP_PEEK;
        send_item(op, pick_ms(), 1'b0, '0);
        sent++;
        if ($urandom_range(99) < 3) settle_pipeline();
      end
    end
    quiet = 1'b0;

    settle_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_frames.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
